// ----- hdl/mlt_pkg.sv -----
`timescale 1ns / 1ps

package mlt_pkg;

    // word prefix storage
    localparam int WORD_PREFIX_CHARS = 5;
    localparam int LEN_W             = $clog2(WORD_PREFIX_CHARS + 2);

    // tokens per input word and token queue depth
    localparam int MAX_TOK   = 4;
    localparam int CNT_W     = $clog2(MAX_TOK + 1);
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam int KIND_W = 5;

    // token kinds
    localparam logic [KIND_W-1:0] TK_NL      = 5'd0;
    localparam logic [KIND_W-1:0] TK_IDENT   = 5'd1;
    localparam logic [KIND_W-1:0] TK_NUM     = 5'd2;
    localparam logic [KIND_W-1:0] TK_TRUE    = 5'd3;
    localparam logic [KIND_W-1:0] TK_FALSE   = 5'd4;
    localparam logic [KIND_W-1:0] TK_PRINT   = 5'd5;
    localparam logic [KIND_W-1:0] TK_IF      = 5'd6;
    localparam logic [KIND_W-1:0] TK_ELSE    = 5'd7;
    localparam logic [KIND_W-1:0] TK_LPAREN  = 5'd8;
    localparam logic [KIND_W-1:0] TK_RPAREN  = 5'd9;
    localparam logic [KIND_W-1:0] TK_AND     = 5'd10;
    localparam logic [KIND_W-1:0] TK_OR      = 5'd11;
    localparam logic [KIND_W-1:0] TK_ASSIGN  = 5'd12;
    localparam logic [KIND_W-1:0] TK_COLON   = 5'd13;
    localparam logic [KIND_W-1:0] TK_EQEQ    = 5'd14;
    localparam logic [KIND_W-1:0] TK_GEQ     = 5'd15;
    localparam logic [KIND_W-1:0] TK_LEQ     = 5'd16;
    localparam logic [KIND_W-1:0] TK_NEQ     = 5'd17;
    localparam logic [KIND_W-1:0] TK_LESS    = 5'd18;
    localparam logic [KIND_W-1:0] TK_GREATER = 5'd19;
    localparam logic [KIND_W-1:0] TK_PLUS    = 5'd20;
    localparam logic [KIND_W-1:0] TK_MINUS   = 5'd21;
    localparam logic [KIND_W-1:0] TK_MULT    = 5'd22;
    localparam logic [KIND_W-1:0] TK_DIV     = 5'd23;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // keyword table, first character at index 0
    localparam int KW_NUM     = 7;
    localparam int KW_MAX_LEN = 5;
    localparam logic [7:0] KW_CHARS [KW_NUM][KW_MAX_LEN] = '{
        '{"T", "r", "u", "e", 8'h00},
        '{"F", "a", "l", "s", "e"},
        '{"p", "r", "i", "n", "t"},
        '{"i", "f", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00},
        '{"a", "n", "d", 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00}
    };
    localparam int KW_LEN [KW_NUM] = '{4, 5, 5, 2, 4, 3, 2};
    localparam logic [KIND_W-1:0] KW_KIND [KW_NUM] = '{
        TK_TRUE, TK_FALSE, TK_PRINT, TK_IF, TK_ELSE, TK_AND, TK_OR
    };

    typedef logic [KIND_W-1:0]                    kind_t;
    typedef logic [LEN_W-1:0]                     len_t;
    typedef logic [WORD_PREFIX_CHARS-1:0][7:0]    prefix_t;

    // one queued token
    typedef struct packed {
        kind_t kind;
        logic  last;
    } tok_t;

    // tokens produced by one accepted word
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        logic [MAX_TOK-1:0][5:0]  tok;
    } tok_bundle_t;

    typedef struct packed {
        logic  ok;
        kind_t kind;
    } tok_opt_t;

    // result of handling one character
    typedef struct packed {
        logic [1:0]      n;
        logic [1:0][KIND_W-1:0] k;
        logic            used;
        prefix_t         prefix;
        len_t            len;
    } proc_t;

    function automatic logic is_delim(logic [7:0] c);
        return c == CH_SPACE || c == CH_EQ || c == CH_LPAREN || c == CH_RPAREN ||
               c == CH_COLON || c == CH_LT || c == CH_GT || c == CH_NL ||
               c == CH_TAB || c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
               c == CH_SLASH;
    endfunction

    // classify the pending word: keyword, number, identifier or nothing
    function automatic tok_opt_t word_token(prefix_t prefix, len_t len);
        tok_opt_t r;
        logic     hit;
        logic     kw_found;
        logic [7:0] first;
        r        = '0;
        kw_found = 1'b0;
        first    = prefix[0];
        for (int k = 0; k < KW_NUM; k++) begin
            hit = (len == len_t'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < KW_LEN[k] && prefix[j] != KW_CHARS[k][j])
                    hit = 1'b0;
            end
            if (hit && !kw_found) begin
                kw_found = 1'b1;
                r.kind   = KW_KIND[k];
            end
        end
        if (len != '0) begin
            if (kw_found) begin
                r.ok = 1'b1;
            end else if (first >= CH_0 && first <= CH_9) begin
                r.ok   = 1'b1;
                r.kind = TK_NUM;
            end else if ((first >= CH_LO_A && first <= CH_LO_Z) ||
                         (first >= CH_UP_A && first <= CH_UP_Z) ||
                         first == CH_USCORE) begin
                r.ok   = 1'b1;
                r.kind = TK_IDENT;
            end
        end
        return r;
    endfunction

    // handle one character against the pending word; at most two tokens
    function automatic proc_t lex_process(logic [7:0] c, logic has_next,
                                          logic [7:0] nx, prefix_t prefix, len_t len);
        proc_t    r;
        tok_opt_t ft;
        logic     app;
        r        = '0;
        r.prefix = prefix;
        r.len    = len;
        ft       = word_token(prefix, len);
        app      = 1'b0;

        // delimiter flushes the word first
        if (is_delim(c)) begin
            if (ft.ok) begin
                r.k[r.n[0]] = ft.kind;
                r.n         = r.n + 2'd1;
            end
            r.len = '0;
        end

        case (c)
            CH_COLON:  begin r.k[r.n[0]] = TK_COLON;  r.n = r.n + 2'd1; end
            CH_LPAREN: begin r.k[r.n[0]] = TK_LPAREN; r.n = r.n + 2'd1; end
            CH_RPAREN: begin r.k[r.n[0]] = TK_RPAREN; r.n = r.n + 2'd1; end
            CH_PLUS:   begin r.k[r.n[0]] = TK_PLUS;   r.n = r.n + 2'd1; end
            CH_MINUS:  begin r.k[r.n[0]] = TK_MINUS;  r.n = r.n + 2'd1; end
            CH_STAR:   begin r.k[r.n[0]] = TK_MULT;   r.n = r.n + 2'd1; end
            CH_SLASH:  begin r.k[r.n[0]] = TK_DIV;    r.n = r.n + 2'd1; end
            default: begin
                if (has_next) begin
                    case (c)
                        CH_EQ: begin
                            r.k[r.n[0]] = (nx == CH_EQ) ? TK_EQEQ : TK_ASSIGN;
                            r.n         = r.n + 2'd1;
                            r.used      = (nx == CH_EQ);
                        end
                        CH_LT: begin
                            r.k[r.n[0]] = (nx == CH_EQ) ? TK_LEQ : TK_LESS;
                            r.n         = r.n + 2'd1;
                            r.used      = (nx == CH_EQ);
                        end
                        CH_GT: begin
                            r.k[r.n[0]] = (nx == CH_EQ) ? TK_GEQ : TK_GREATER;
                            r.n         = r.n + 2'd1;
                            r.used      = (nx == CH_EQ);
                        end
                        CH_BANG: begin
                            if (nx == CH_EQ) begin
                                // not-equal flushes the word itself
                                if (ft.ok) begin
                                    r.k[r.n[0]] = ft.kind;
                                    r.n         = r.n + 2'd1;
                                end
                                r.len       = '0;
                                r.k[r.n[0]] = TK_NEQ;
                                r.n         = r.n + 2'd1;
                                r.used      = 1'b1;
                            end else begin
                                app = 1'b1;
                            end
                        end
                        CH_SPACE, CH_NL, CH_TAB: app = 1'b0;
                        default: app = 1'b1;
                    endcase
                end
            end
        endcase

        // append to the word; length saturates one past the prefix
        if (app) begin
            for (int i = 0; i < WORD_PREFIX_CHARS; i++) begin
                if (len == len_t'(i))
                    r.prefix[i] = c;
            end
            if (len < len_t'(WORD_PREFIX_CHARS + 1))
                r.len = len + len_t'(1);
        end

        if (c == CH_NL) begin
            r.k[r.n[0]] = TK_NL;
            r.n         = r.n + 2'd1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/mlt_lexer.sv -----
`timescale 1ns / 1ps

module mlt_lexer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [7:0]           char_code,
    input  logic                 end_of_text,
    output mlt_pkg::tok_bundle_t bundle
);

    logic [7:0]       held_char_reg, held_char_next;
    logic             held_valid_reg, held_valid_next;
    mlt_pkg::len_t    len_reg, len_next;
    mlt_pkg::prefix_t prefix_reg;

    mlt_pkg::proc_t   p1_raw, p1, p2;
    logic             used;
    logic             do2;
    logic [1:0]       n1, n2;
    logic [mlt_pkg::CNT_W-1:0] total;
    mlt_pkg::kind_t   kinds [mlt_pkg::MAX_TOK];

    // held byte with the new byte as lookahead, then the new byte on end of text
    always_comb begin
        p1_raw = mlt_pkg::lex_process(held_char_reg, 1'b1, char_code, prefix_reg, len_reg);
        if (held_valid_reg) begin
            p1 = p1_raw;
        end else begin
            p1        = '0;
            p1.prefix = prefix_reg;
            p1.len    = len_reg;
        end
        used = p1.used;
        do2  = end_of_text && !used;
        p2   = mlt_pkg::lex_process(char_code, 1'b0, 8'h00, p1.prefix, p1.len);
        n1   = p1.n;
        n2   = do2 ? p2.n : 2'd0;
    end

    // merge the two token lists in order
    always_comb begin
        for (int i = 0; i < mlt_pkg::MAX_TOK; i++)
            kinds[i] = '0;
        case (n1)
            2'd0: begin
                kinds[0] = p2.k[0];
                kinds[1] = p2.k[1];
            end
            2'd1: begin
                kinds[0] = p1.k[0];
                kinds[1] = p2.k[0];
                kinds[2] = p2.k[1];
            end
            default: begin
                kinds[0] = p1.k[0];
                kinds[1] = p1.k[1];
                kinds[2] = p2.k[0];
                kinds[3] = p2.k[1];
            end
        endcase
        total = mlt_pkg::CNT_W'(n1) + mlt_pkg::CNT_W'(n2);
        bundle.cnt = in_fire ? total : '0;
        for (int i = 0; i < mlt_pkg::MAX_TOK; i++)
            bundle.tok[i] = {kinds[i], (total == mlt_pkg::CNT_W'(i + 1))};
    end

    // lookahead and word state
    always_comb begin
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        len_next        = len_reg;
        if (in_fire) begin
            len_next = p1.len;
            if (end_of_text) begin
                held_valid_next = 1'b0;
                held_char_next  = 8'h00;
                len_next        = '0;
            end else if (used) begin
                held_valid_next = 1'b0;
            end else begin
                held_char_next  = char_code;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_char_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            len_reg        <= '0;
        end else begin
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            len_reg        <= len_next;
        end
    end

    // prefix bytes, meaningful only below the length
    always_ff @(posedge aclk) begin
        if (in_fire)
            prefix_reg <= p1.prefix;
    end

    a_first_byte_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !held_valid_reg && !end_of_text) |-> (bundle.cnt == '0))
        else $error("first byte of a text produced tokens");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && end_of_text) |=> (!held_valid_reg && len_reg == '0))
        else $error("end of text left state behind");

    a_len_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= mlt_pkg::len_t'(mlt_pkg::WORD_PREFIX_CHARS + 1))
        else $error("word length beyond saturation");

endmodule

// ----- hdl/mlt_tok_fifo.sv -----
`timescale 1ns / 1ps

module mlt_tok_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mlt_pkg::tok_bundle_t wr,
    output logic                 room,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output mlt_pkg::tok_t        rd_tok
);

    mlt_pkg::tok_t                mem_reg [mlt_pkg::FIFO_DEPTH];
    logic [mlt_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mlt_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mlt_pkg::FCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         pop;

    assign room     = (cnt_reg <= mlt_pkg::FCNT_W'(mlt_pkg::FIFO_DEPTH - mlt_pkg::MAX_TOK));
    assign rd_valid = (cnt_reg != '0);
    assign rd_tok   = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + mlt_pkg::PTR_W'(wr.cnt);
        rd_ptr_next = rd_ptr_reg + mlt_pkg::PTR_W'(pop);
        cnt_next    = cnt_reg + mlt_pkg::FCNT_W'(wr.cnt) - mlt_pkg::FCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // up to four token writes per cycle
    always_ff @(posedge aclk) begin
        for (int i = 0; i < mlt_pkg::MAX_TOK; i++) begin
            if (mlt_pkg::CNT_W'(i) < wr.cnt)
                mem_reg[wr_ptr_reg + mlt_pkg::PTR_W'(i)] <= wr.tok[i];
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.cnt != '0) |-> room)
        else $error("token write without room");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= mlt_pkg::FCNT_W'(mlt_pkg::FIFO_DEPTH))
        else $error("token count over depth");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && wr.cnt == '0) |=> (cnt_reg == $past(cnt_reg) - mlt_pkg::FCNT_W'(1)))
        else $error("token count did not drop on read");

endmodule

// ----- hdl/mini_language_tokenizer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  tdata                     tlast
// s_        in   [7:0] char_code           end_of_text
// m_        out  [4:0] token_kind, 0 pad   last_of_run
//
// One character word is taken per cycle while the token queue holds four or
// fewer tokens; the scan and keyword compare finish in the accepting cycle.
// Each character yields zero to four tokens into an eight-entry queue that
// drains one token per cycle, so output bandwidth sets the sustained rate.
// Synchronous active-low reset clears the lookahead, word length and queue.
// A stall on m_ only drops s_tready once the queue passes four tokens.

module mini_language_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] token_kind, [7:5] zero
    output logic       m_tlast
);

    mlt_pkg::tok_bundle_t bundle;
    mlt_pkg::tok_t        rd_tok;
    logic                 room;
    logic                 in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    mlt_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .bundle      (bundle)
    );

    mlt_tok_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (bundle),
        .room     (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_tok   (rd_tok)
    );

    assign m_tdata = {3'b000, rd_tok.kind};
    assign m_tlast = rd_tok.last;

endmodule
